FILE: src/tpc_pkg.sv
package tpc_pkg;

   // word layout of one vertex and one triangle on the stream ports
   localparam int POS_W  = 64;
   localparam int COL_W  = 24;
   localparam int VTX_W  = POS_W + COL_W;
   localparam int DATA_W = 3 * VTX_W;

   // configuration port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;
   localparam int REG_W  = 16;

   // fixed-point formats
   localparam int FRAC_BITS = 8;
   localparam int T_FRAC    = 16;
   localparam int T_W       = T_FRAC + 1;

   // register map, word index
   typedef enum logic [1:0] {
      REG_NORMAL_X = 2'd0,
      REG_NORMAL_Y = 2'd1,
      REG_NORMAL_Z = 2'd2,
      REG_OFFSET   = 2'd3
   } csr_reg_type;

   // how the plane cuts a triangle
   typedef enum logic [1:0] {
      KIND_ALL_IN  = 2'd0,
      KIND_ONE_OUT = 2'd1,
      KIND_TWO_OUT = 2'd2,
      KIND_ALL_OUT = 2'd3
   } clip_kind_type;

endpackage

FILE: src/triangle_plane_clipper_top.sv
// channel  dir  handshake             payload
// req      in   req_tvalid/tready     one triangle word (3 x position, color)
// rsp      out  rsp_tvalid/tready     one triangle word, rsp_tlast on final one
// csr      in   apb psel/penable      plane normal x/y/z, plane offset
//
// pipeline from req accept to rsp_tvalid: w divide COMPONENT_WIDTH + 8 stages,
// distance 3, classify 1, edge divide 17, then lerp and the rsp register.
// a word enters every cycle unless stalled; a split triangle sends two words in turn.
// when the rsp register is full and not draining, every stage holds its contents.
// reset clears all valid bits and sets the plane registers to zero.
module triangle_plane_clipper_top
   import tpc_pkg::*;
#(
   parameter int COMPONENT_WIDTH = 16,
   parameter int COLOR_WIDTH     = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // vertex0_position, vertex0_color, vertex1_position, vertex1_color,
   // vertex2_position, vertex2_color
   input  logic [DATA_W-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // out_vertex0_position, out_vertex0_color, out_vertex1_position,
   // out_vertex1_color, out_vertex2_position, out_vertex2_color
   output logic [DATA_W-1:0] rsp_tdata,
   output logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int CW  = COMPONENT_WIDTH;
   localparam int KW  = COLOR_WIDTH;
   localparam int QW  = CW + FRAC_BITS;
   localparam int PW  = REG_W + CW;
   localparam int DW  = PW + 2;
   localparam int EW  = DW + 1;
   localparam int PPW = CW + T_W + 2;

   typedef struct packed {
      logic [3:0][CW-1:0] p;
      logic [2:0][KW-1:0] c;
   } vert_type;

   typedef vert_type [2:0] trgl_type;

   typedef struct packed {
      clip_kind_type kind;
      trgl_type      raw;
      vert_type      a;
      vert_type      b;
      vert_type      o0;
      vert_type      o1;
   } edge_item_type;

   function automatic trgl_type unpack_trgl(input logic [DATA_W-1:0] d);
      trgl_type         r;
      logic [POS_W-1:0] pos;
      logic [COL_W-1:0] col;
      for (int j = 0; j < 3; j++) begin
         pos = d[j*VTX_W +: POS_W];
         col = d[j*VTX_W+POS_W +: COL_W];
         for (int k = 0; k < 4; k++) r[j].p[k] = pos[k*CW +: CW];
         for (int k = 0; k < 3; k++) r[j].c[k] = col[k*KW +: KW];
      end
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] pack_trgl(input trgl_type r);
      logic [DATA_W-1:0] d;
      d = '0;
      for (int j = 0; j < 3; j++) begin
         d[j*VTX_W +: POS_W]       = POS_W'(r[j].p);
         d[j*VTX_W+POS_W +: COL_W] = COL_W'(r[j].c);
      end
      return d;
   endfunction

   // signed quotient from magnitudes, saturated to the component range
   function automatic logic [CW-1:0] sat_quo(input logic [QW-1:0] q,
                                             input logic [CW-1:0] a,
                                             input logic [CW-1:0] w);
      logic neg;
      logic big;
      neg = a[CW-1] ^ w[CW-1];
      big = q >= (QW'(1) << (CW-1));
      if (a == '0)
         return '0;
      else if (neg)
         return big ? {1'b1, {(CW-1){1'b0}}} : CW'(-q);
      else
         return big ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
   endfunction

   // round to nearest, ties away from zero, dropping the t fraction
   function automatic logic [PPW-1:0] round_t(input logic [PPW-1:0] v);
      logic [PPW-1:0] mag;
      logic [PPW-1:0] r;
      mag = v[PPW-1] ? -v : v;
      r   = (mag + (PPW'(1) << (T_FRAC-1))) >> T_FRAC;
      return v[PPW-1] ? -r : r;
   endfunction

   localparam logic [CW-1:0] W_ONE = CW'(1) << FRAC_BITS;

   logic adv;

   // ---------------------------------------------------------------- config
   logic signed [REG_W-1:0] cfg_n_ff [3];
   logic signed [REG_W-1:0] cfg_d_ff;
   logic                    csr_wr;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // register write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_n_ff[0] <= '0;
         cfg_n_ff[1] <= '0;
         cfg_n_ff[2] <= '0;
         cfg_d_ff    <= '0;
      end else if (csr_wr) begin
         unique case (csr_reg_type'(csr_paddr[CSR_AW-1:2]))
            REG_NORMAL_X: cfg_n_ff[0] <= csr_pwdata[REG_W-1:0];
            REG_NORMAL_Y: cfg_n_ff[1] <= csr_pwdata[REG_W-1:0];
            REG_NORMAL_Z: cfg_n_ff[2] <= csr_pwdata[REG_W-1:0];
            REG_OFFSET:   cfg_d_ff    <= csr_pwdata[REG_W-1:0];
         endcase
      end
   end

   // register read
   always_comb begin
      unique case (csr_reg_type'(csr_paddr[CSR_AW-1:2]))
         REG_NORMAL_X: csr_prdata = CSR_DW'(unsigned'(cfg_n_ff[0]));
         REG_NORMAL_Y: csr_prdata = CSR_DW'(unsigned'(cfg_n_ff[1]));
         REG_NORMAL_Z: csr_prdata = CSR_DW'(unsigned'(cfg_n_ff[2]));
         REG_OFFSET:   csr_prdata = CSR_DW'(unsigned'(cfg_d_ff));
      endcase
   end

   // ---------------------------------------------------------------- w divide
   trgl_type         in_trgl;
   logic [QW-1:0]    wnum [3][3];
   logic [CW-1:0]    wden [3];
   logic [QW-1:0]    wquo [3][3];
   trgl_type         raw_ff [QW];
   logic [QW-1:0]    wvld_ff;

   // magnitudes into the dividers
   always_comb begin
      in_trgl = unpack_trgl(req_tdata);
      for (int v = 0; v < 3; v++) begin
         wden[v] = in_trgl[v].p[3][CW-1] ? CW'(-in_trgl[v].p[3]) : in_trgl[v].p[3];
         for (int k = 0; k < 3; k++) begin
            wnum[v][k] = {in_trgl[v].p[k][CW-1] ? CW'(-in_trgl[v].p[k]) : in_trgl[v].p[k],
                          {FRAC_BITS{1'b0}}};
         end
      end
   end

   for (genvar v = 0; v < 3; v++) begin : g_wv
      for (genvar k = 0; k < 3; k++) begin : g_wk
         tpc_div_pipe #(.DEN_W(CW), .QUO_W(QW)) u_wdiv (
            .clock    (clock),
            .adv      (adv),
            .rem_init ('0),
            .num_low  (wnum[v][k]),
            .den      (wden[v]),
            .quo      (wquo[v][k])
         );
      end
   end

   // raw triangle travels beside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         wvld_ff <= '0;
      end else if (adv) begin
         wvld_ff <= {wvld_ff[QW-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         raw_ff[0] <= in_trgl;
         for (int s = 1; s < QW; s++) raw_ff[s] <= raw_ff[s-1];
      end
   end

   // ---------------------------------------------------------------- distance
   trgl_type             b1_nv_in, b1_nv_ff, b2_nv_ff, b3_nv_ff;
   trgl_type             b1_raw_ff, b2_raw_ff, b3_raw_ff;
   logic [2:0]           bvld_ff;
   logic signed [PW-1:0] prod_in [3][3];
   logic signed [PW-1:0] prod_ff [3][3];
   logic signed [DW-1:0] dist_in [3];
   logic signed [DW-1:0] dist_ff [3];

   // saturate quotients, w becomes one
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         for (int k = 0; k < 3; k++) begin
            b1_nv_in[v].p[k] = sat_quo(wquo[v][k], raw_ff[QW-1][v].p[k],
                                       raw_ff[QW-1][v].p[3]);
         end
         b1_nv_in[v].p[3] = W_ONE;
         b1_nv_in[v].c    = raw_ff[QW-1][v].c;
      end
   end

   // normal times position
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[v][k] = cfg_n_ff[k] * $signed(b1_nv_ff[v].p[k]);
         end
      end
   end

   // sum plus offset
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         dist_in[v] = DW'(prod_ff[v][0]) + DW'(prod_ff[v][1]) + DW'(prod_ff[v][2])
                    + (DW'(cfg_d_ff) <<< FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bvld_ff <= '0;
      end else if (adv) begin
         bvld_ff <= {bvld_ff[1:0], wvld_ff[QW-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_nv_ff  <= b1_nv_in;
         b1_raw_ff <= raw_ff[QW-1];
         prod_ff   <= prod_in;
         b2_nv_ff  <= b1_nv_ff;
         b2_raw_ff <= b1_raw_ff;
         dist_ff   <= dist_in;
         b3_nv_ff  <= b2_nv_ff;
         b3_raw_ff <= b2_raw_ff;
      end
   end

   // ---------------------------------------------------------------- classify
   logic [2:0]      ins;
   logic [1:0]      ia, ib, oa, ob, ie1;
   edge_item_type   c1_item_in, c1_item_ff;
   logic [EW-1:0]   ndi_in [2];
   logic [EW-1:0]   den_in [2];
   logic [EW-1:0]   ndi_ff [2];
   logic [EW-1:0]   den_ff [2];
   logic            c1_vld_ff;

   always_comb begin
      for (int v = 0; v < 3; v++) ins[v] = dist_ff[v][DW-1];
      ia = 2'd0;
      ib = 2'd1;
      oa = 2'd1;
      ob = 2'd2;
      c1_item_in.kind = KIND_ALL_IN;
      unique case (ins)
         3'b111: c1_item_in.kind = KIND_ALL_IN;
         3'b000: c1_item_in.kind = KIND_ALL_OUT;
         // one vertex outside
         3'b110: begin
            c1_item_in.kind = KIND_ONE_OUT;
            ia = 2'd1; ib = 2'd2; oa = 2'd0; ob = 2'd0;
         end
         3'b101: begin
            c1_item_in.kind = KIND_ONE_OUT;
            ia = 2'd0; ib = 2'd2; oa = 2'd1; ob = 2'd1;
         end
         3'b011: begin
            c1_item_in.kind = KIND_ONE_OUT;
            ia = 2'd0; ib = 2'd1; oa = 2'd2; ob = 2'd2;
         end
         // two vertices outside
         3'b001: begin
            c1_item_in.kind = KIND_TWO_OUT;
            ia = 2'd0; ib = 2'd0; oa = 2'd1; ob = 2'd2;
         end
         3'b010: begin
            c1_item_in.kind = KIND_TWO_OUT;
            ia = 2'd1; ib = 2'd1; oa = 2'd0; ob = 2'd2;
         end
         3'b100: begin
            c1_item_in.kind = KIND_TWO_OUT;
            ia = 2'd2; ib = 2'd2; oa = 2'd0; ob = 2'd1;
         end
      endcase
      ie1 = (c1_item_in.kind == KIND_ONE_OUT) ? ib : ia;
      c1_item_in.raw = b3_raw_ff;
      c1_item_in.a   = b3_nv_ff[ia];
      c1_item_in.b   = b3_nv_ff[ib];
      c1_item_in.o0  = b3_nv_ff[oa];
      c1_item_in.o1  = b3_nv_ff[ob];
      ndi_in[0] = EW'(-dist_ff[ia]);
      den_in[0] = EW'(dist_ff[oa]) - EW'(dist_ff[ia]);
      ndi_in[1] = EW'(-dist_ff[ie1]);
      den_in[1] = EW'(dist_ff[ob]) - EW'(dist_ff[ie1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff <= 1'b0;
      end else if (adv) begin
         c1_vld_ff <= bvld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_item_ff <= c1_item_in;
         ndi_ff     <= ndi_in;
         den_ff     <= den_in;
      end
   end

   // ---------------------------------------------------------------- edge divide
   logic [T_W-1:0]  tq [2];
   edge_item_type   edl_ff [T_W];
   logic [T_W-1:0]  evld_ff;

   // -dI < 2*den keeps the top quotient bits zero, so start with -dI / 2
   for (genvar e = 0; e < 2; e++) begin : g_te
      tpc_div_pipe #(.DEN_W(EW), .QUO_W(T_W)) u_tdiv (
         .clock    (clock),
         .adv      (adv),
         .rem_init (ndi_ff[e] >> 1),
         .num_low  ({ndi_ff[e][0], {T_FRAC{1'b0}}}),
         .den      (den_ff[e]),
         .quo      (tq[e])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         evld_ff <= '0;
      end else if (adv) begin
         evld_ff <= {evld_ff[T_W-2:0], c1_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         edl_ff[0] <= c1_item_ff;
         for (int s = 1; s < T_W; s++) edl_ff[s] <= edl_ff[s-1];
      end
   end

   // ---------------------------------------------------------------- lerp
   edge_item_type         d1_item_ff;
   logic                  d1_vld_ff;
   logic [PPW-1:0]        pp_in [2][6];
   logic [PPW-1:0]        pp_ff [2][6];
   vert_type              ev_i [2];
   vert_type              ev_o [2];
   logic signed [CW:0]    dpos;
   logic signed [KW:0]    dcol;
   logic signed [T_W:0]   tt;

   // (O - I) * t per channel, both edges
   always_comb begin
      ev_i[0] = edl_ff[T_W-1].a;
      ev_i[1] = (edl_ff[T_W-1].kind == KIND_ONE_OUT) ? edl_ff[T_W-1].b : edl_ff[T_W-1].a;
      ev_o[0] = edl_ff[T_W-1].o0;
      ev_o[1] = edl_ff[T_W-1].o1;
      dpos = '0;
      dcol = '0;
      tt   = '0;
      for (int e = 0; e < 2; e++) begin
         tt = $signed({1'b0, tq[e]});
         for (int k = 0; k < 3; k++) begin
            dpos = (CW+1)'($signed(ev_o[e].p[k])) - (CW+1)'($signed(ev_i[e].p[k]));
            pp_in[e][k] = PPW'(dpos * tt);
            dcol = $signed({1'b0, ev_o[e].c[k]}) - $signed({1'b0, ev_i[e].c[k]});
            pp_in[e][3+k] = PPW'(dcol * tt);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_vld_ff <= 1'b0;
      end else if (adv) begin
         d1_vld_ff <= evld_ff[T_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_item_ff <= edl_ff[T_W-1];
         pp_ff      <= pp_in;
      end
   end

   // ---------------------------------------------------------------- result register
   vert_type      nv_i [2];
   vert_type      pnew [2];
   trgl_type      res0_in, res1_in;
   trgl_type      res0_ff, res1_ff;
   logic          two_in;
   logic          obuf_vld_in, obuf_vld_ff;
   logic          obuf_two_ff;
   logic          obuf_sel_in, obuf_sel_ff;
   logic          out_last;

   // new vertices and the triangles they form
   always_comb begin
      nv_i[0] = d1_item_ff.a;
      nv_i[1] = (d1_item_ff.kind == KIND_ONE_OUT) ? d1_item_ff.b : d1_item_ff.a;
      for (int e = 0; e < 2; e++) begin
         for (int k = 0; k < 3; k++) begin
            pnew[e].p[k] = nv_i[e].p[k] + CW'(round_t(pp_ff[e][k]));
            pnew[e].c[k] = nv_i[e].c[k] + KW'(round_t(pp_ff[e][3+k]));
         end
         pnew[e].p[3] = W_ONE;
      end
      res0_in    = d1_item_ff.raw;
      res1_in[0] = d1_item_ff.a;
      res1_in[1] = pnew[1];
      res1_in[2] = d1_item_ff.b;
      two_in     = 1'b0;
      unique case (d1_item_ff.kind)
         KIND_ALL_IN: res0_in = d1_item_ff.raw;
         KIND_ONE_OUT: begin
            res0_in[0] = d1_item_ff.a;
            res0_in[1] = pnew[0];
            res0_in[2] = pnew[1];
            two_in     = 1'b1;
         end
         KIND_TWO_OUT: begin
            res0_in[0] = d1_item_ff.a;
            res0_in[1] = pnew[0];
            res0_in[2] = pnew[1];
         end
         KIND_ALL_OUT: two_in = 1'b0;
      endcase
   end

   // output handshake and pipeline advance
   assign out_last = !obuf_two_ff || obuf_sel_ff;
   assign adv      = !obuf_vld_ff || (rsp_tready && out_last);

   always_comb begin
      obuf_vld_in = obuf_vld_ff;
      obuf_sel_in = obuf_sel_ff;
      if (adv) begin
         obuf_vld_in = d1_vld_ff && (d1_item_ff.kind != KIND_ALL_OUT);
         obuf_sel_in = 1'b0;
      end else if (rsp_tready) begin
         obuf_sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obuf_vld_ff <= 1'b0;
         obuf_sel_ff <= 1'b0;
         obuf_two_ff <= 1'b0;
      end else begin
         obuf_vld_ff <= obuf_vld_in;
         obuf_sel_ff <= obuf_sel_in;
         if (adv) obuf_two_ff <= two_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res0_ff <= res0_in;
         res1_ff <= res1_in;
      end
   end

   assign req_tready = adv;
   assign rsp_tvalid = obuf_vld_ff;
   assign rsp_tlast  = out_last;
   assign rsp_tdata  = pack_trgl(obuf_sel_ff ? res1_ff : res0_ff);

endmodule

FILE: src/tpc_div_pipe.sv
module tpc_div_pipe #(
   parameter int DEN_W = 16,
   parameter int QUO_W = 24
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [DEN_W-1:0] rem_init,
   input  logic [QUO_W-1:0] num_low,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] low_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   // one restoring step per stage, quotient msb first
   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      logic [DEN_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] low_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [DEN_W:0]   trial;
      logic             ge;
      logic [DEN_W-1:0] rem_in;

      if (s == 0) begin : g_first
         assign rem_prev = rem_init;
         assign den_prev = den;
         assign low_prev = num_low;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign low_prev = low_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      assign trial  = {rem_prev, low_prev[QUO_W-1]};
      assign ge     = trial >= {1'b0, den_prev};
      assign rem_in = ge ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_prev;
            low_ff[s] <= low_prev << 1;
            quo_ff[s] <= {quo_prev[QUO_W-2:0], ge};
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

FILE: src/tpc_checker.sv
module tpc_checker
   import tpc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tlast
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // reset empties the result register
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // first half of a split triangle is followed at once by the final half
   a_rsp_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("second triangle of a split missing");

   // input stalls only while a result waits that is not leaving as final word
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !(rsp_tready && rsp_tlast))
      else $error("req stalled without a blocked result");

endmodule

bind triangle_plane_clipper_top tpc_checker u_tpc_checker (.*);

FILE: sim/tb_triangle_plane_clipper_top.sv
module tb_triangle_plane_clipper_top;
   import tpc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW   = 16;
   localparam int KW   = 8;
   localparam int SAFE = 80;   // idle cycles after the last expected result

   typedef struct {
      longint p[4];
      longint c[3];
   } vtx_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              last;
   } tri_word_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tlast;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // plane registers as the block should hold them
   logic [REG_W-1:0] plane_reg [4];
   tri_word_type     expected_tris [$];
   int               error_count;
   int               send_idle_pct;
   int               recv_idle_pct;
   int               recv_hold_cycles;
   logic             recv_hold;
   event             word_taken;
   event             hold_off_start;

   triangle_plane_clipper_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // fixed-point helpers
   function automatic longint sat_comp(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint round_t(longint v);
      if (v >= 0) return (v + 32768) >>> T_FRAC;
      return -(((-v) + 32768) >>> T_FRAC);
   endfunction

   function automatic longint reg_val(csr_reg_type r);
      return longint'($signed(plane_reg[r]));
   endfunction

   function automatic vtx_type unpack_vtx(logic [VTX_W-1:0] w);
      vtx_type v;
      for (int i = 0; i < 4; i++) v.p[i] = longint'($signed(w[i*CW +: CW]));
      for (int i = 0; i < 3; i++) v.c[i] = longint'(w[POS_W + i*KW +: KW]);
      return v;
   endfunction

   function automatic logic [VTX_W-1:0] pack_vtx(vtx_type v);
      logic [VTX_W-1:0] w;
      w = '0;
      for (int i = 0; i < 4; i++) w[i*CW +: CW] = v.p[i][CW-1:0];
      for (int i = 0; i < 3; i++) w[POS_W + i*KW +: KW] = v.c[i][KW-1:0];
      return w;
   endfunction

   // perspective divide, saturating
   function automatic vtx_type divide_by_w(vtx_type v);
      vtx_type r;
      longint  q;
      r = v;
      for (int i = 0; i < 3; i++) begin
         if (v.p[3] == 0)
            q = v.p[i] > 0 ? 32767 : (v.p[i] < 0 ? -32768 : 0);
         else
            q = (v.p[i] * 256) / v.p[3];
         r.p[i] = sat_comp(q);
      end
      r.p[3] = 256;
      return r;
   endfunction

   function automatic longint plane_dist(vtx_type v);
      return reg_val(REG_NORMAL_X) * v.p[0] + reg_val(REG_NORMAL_Y) * v.p[1]
           + reg_val(REG_NORMAL_Z) * v.p[2] + reg_val(REG_OFFSET) * 256;
   endfunction

   // intersection of edge inside->outside with the plane
   function automatic vtx_type edge_point(vtx_type vi, vtx_type vo);
      vtx_type r;
      longint  di;
      longint  dd;
      longint  t;
      di = plane_dist(vi);
      dd = plane_dist(vo);
      t  = (-di * 65536) / (dd - di);
      for (int i = 0; i < 3; i++) r.p[i] = sat_comp(vi.p[i] + round_t((vo.p[i] - vi.p[i]) * t));
      r.p[3] = 256;
      for (int i = 0; i < 3; i++) r.c[i] = vi.c[i] + round_t((vo.c[i] - vi.c[i]) * t);
      return r;
   endfunction

   function automatic void push_tri(vtx_type a, vtx_type b, vtx_type c, logic last);
      tri_word_type e;
      e.data = {pack_vtx(c), pack_vtx(b), pack_vtx(a)};
      e.last = last;
      expected_tris.insert(expected_tris.size(), e);
   endfunction

   // expected triangles for one input triangle
   function automatic void clip_triangle(logic [DATA_W-1:0] d);
      vtx_type raw [3];
      vtx_type nv  [3];
      int      ins [3];
      int      outs[3];
      int      ni;
      int      no;
      vtx_type p1;
      vtx_type p2;
      ni = 0;
      no = 0;
      for (int i = 0; i < 3; i++) begin
         raw[i] = unpack_vtx(d[i*VTX_W +: VTX_W]);
         nv[i]  = divide_by_w(raw[i]);
         if (plane_dist(nv[i]) < 0) begin
            ins[ni] = i;
            ni++;
         end else begin
            outs[no] = i;
            no++;
         end
      end
      if (ni == 3) begin
         push_tri(raw[0], raw[1], raw[2], 1'b1);
      end else if (no == 1) begin
         p1 = edge_point(nv[ins[0]], nv[outs[0]]);
         p2 = edge_point(nv[ins[1]], nv[outs[0]]);
         push_tri(nv[ins[0]], p1, p2, 1'b0);
         push_tri(nv[ins[0]], p2, nv[ins[1]], 1'b1);
      end else if (no == 2) begin
         p1 = edge_point(nv[ins[0]], nv[outs[0]]);
         p2 = edge_point(nv[ins[0]], nv[outs[1]]);
         push_tri(nv[ins[0]], p1, p2, 1'b1);
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // accepted input words feed the predictor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         clip_triangle(req_tdata);
         -> word_taken;
      end
   end

   // result checker
   always @(posedge clock) begin
      tri_word_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tris.size() == 0) begin
            report_mismatch("unexpected triangle", rsp_tdata[63:0], 64'd0);
         end else begin
            e = expected_tris.pop_front();
            for (int k = 0; k < 3; k++) begin
               if (rsp_tdata[k*VTX_W +: POS_W] !== e.data[k*VTX_W +: POS_W])
                  report_mismatch($sformatf("vertex%0d position", k),
                                  rsp_tdata[k*VTX_W +: POS_W], e.data[k*VTX_W +: POS_W]);
               if (rsp_tdata[k*VTX_W + POS_W +: COL_W] !== e.data[k*VTX_W + POS_W +: COL_W])
                  report_mismatch($sformatf("vertex%0d color", k),
                                  rsp_tdata[k*VTX_W + POS_W +: COL_W],
                                  e.data[k*VTX_W + POS_W +: COL_W]);
            end
            if (rsp_tlast !== e.last) report_mismatch("last", rsp_tlast, e.last);
         end
      end
   end

   // long receiver hold-off, counted here
   initial begin
      recv_hold = 1'b0;
      forever begin
         @(hold_off_start);
         recv_hold <= 1'b1;
         repeat (recv_hold_cycles) @(posedge clock);
         recv_hold <= 1'b0;
      end
   end

   // receiver with random stalls
   always @(posedge clock) begin
      if (recv_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // one word on the request side, called just after a rising edge
   task automatic send_triangle(logic [DATA_W-1:0] d);
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(word_taken);
   endtask

   // let everything in flight come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_tris.size() != 0) @(posedge clock);
      repeat (SAFE) @(posedge clock);
   endtask

   task automatic write_plane(csr_reg_type r, logic [REG_W-1:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= {{(CSR_DW-REG_W){v[REG_W-1]}}, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      plane_reg[r] = v;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz, logic [15:0] d);
      drain_results();
      write_plane(REG_NORMAL_X, nx);
      write_plane(REG_NORMAL_Y, ny);
      write_plane(REG_NORMAL_Z, nz);
      write_plane(REG_OFFSET, d);
      @(posedge clock);
   endtask

   function automatic logic [VTX_W-1:0] make_vtx(int x, int y, int z, int w, logic [23:0] c);
      return {c, w[15:0], z[15:0], y[15:0], x[15:0]};
   endfunction

   // random vertex, mostly well-scaled, sometimes raw bits
   function automatic logic [VTX_W-1:0] rand_vtx();
      logic [VTX_W-1:0] v;
      int               sel;
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
         v = VTX_W'({$urandom(), $urandom(), $urandom()});
      end else begin
         v = make_vtx($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
                      $urandom_range(0, 4096) - 2048,
                      sel == 2 ? $urandom_range(0, 4) - 2 : $urandom_range(64, 1024),
                      24'($urandom()));
      end
      return v;
   endfunction

   function automatic logic [DATA_W-1:0] rand_triangle();
      return {rand_vtx(), rand_vtx(), rand_vtx()};
   endfunction

   // plane at its reset value puts every vertex on the plane, which counts as outside: nothing out
   task automatic test_reset_plane();
      send_triangle({3{make_vtx(100, -100, 5, 256, 24'h123456)}});
      send_triangle('0);
      send_triangle('1);
   endtask

   // every vertex inside, including the field extremes
   task automatic test_all_inside();
      set_plane(16'h0100, 16'h0000, 16'h0000, 16'h8000);
      send_triangle('0);
      send_triangle('1);
      send_triangle({make_vtx(32767, 32767, 32767, 32767, 24'hffffff),
                     make_vtx(-32768, -32768, -32768, -32768, 24'h000000),
                     make_vtx(1, 2, 3, 256, 24'h808080)});
   endtask

   // plane x = 0: one or two vertices cut off, zero w too
   task automatic test_clip_cases();
      set_plane(16'h0100, 16'h0000, 16'h0000, 16'h0000);
      send_triangle({make_vtx(-256, 0, 0, 256, 24'h0000ff),
                     make_vtx(-512, 256, 0, 256, 24'h00ff00),
                     make_vtx(512, 0, 0, 256, 24'hff0000)});
      send_triangle({make_vtx(300, 10, 0, 256, 24'hffffff),
                     make_vtx(-700, 40, 9, 512, 24'h000000),
                     make_vtx(-90, -30, 1, 128, 24'h7f3c21)});
      send_triangle({make_vtx(-256, 0, 0, 256, 24'h102030),
                     make_vtx(256, 256, 0, 256, 24'hf0e0d0),
                     make_vtx(700, -256, 3, 300, 24'h00ff80)});
      send_triangle({make_vtx(-300, 0, 0, 256, 24'h112233),
                     make_vtx(-100, 0, 0, 256, 24'h445566),
                     make_vtx(500, 0, 0, 256, 24'h778899)});
      // zero w: positive, negative and zero numerators
      send_triangle({make_vtx(5, 1, 1, 0, 24'haabbcc),
                     make_vtx(-5, 0, 0, 0, 24'h010203),
                     make_vtx(0, 9, 9, 0, 24'hfefdfc)});
      send_triangle({make_vtx(-1, 0, 0, 0, 24'h00ffff),
                     make_vtx(-40, 0, 0, -256, 24'hff00ff),
                     make_vtx(40, 0, 0, -256, 24'hffff00)});
      // extreme plane values
      set_plane(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_triangle({make_vtx(-32768, 32767, -32768, 256, 24'hffffff),
                     make_vtx(32767, -32768, 32767, 256, 24'h000000),
                     make_vtx(0, 0, 0, 256, 24'h5a5a5a)});
      send_triangle({make_vtx(32767, 32767, 32767, 1, 24'h0f0f0f),
                     make_vtx(-32768, -32768, -32768, 1, 24'hf0f0f0),
                     make_vtx(100, 200, 300, 256, 24'hc3c3c3)});
   endtask

   // random planes and triangles
   task automatic test_random(int n_sets, int per_set);
      for (int s = 0; s < n_sets; s++) begin
         if ($urandom_range(0, 3) == 0)
            set_plane(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
         else
            set_plane(16'($urandom_range(0, 1024) - 512), 16'($urandom_range(0, 1024) - 512),
                      16'($urandom_range(0, 1024) - 512), 16'($urandom_range(0, 512) - 256));
         for (int i = 0; i < per_set; i++) send_triangle(rand_triangle());
      end
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      send_idle_pct    = 0;
      recv_hold_cycles = 400;
      -> hold_off_start;
      for (int i = 0; i < 70; i++) send_triangle(rand_triangle());
      drain_results();
   endtask

   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      rsp_tready       = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      error_count      = 0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      recv_hold_cycles = 0;
      for (int i = 0; i < 4; i++) plane_reg[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 28;
      recv_idle_pct = 77;
      test_reset_plane();
      test_all_inside();
      test_clip_cases();
      test_random(3, 90);

      send_idle_pct = 77;
      recv_idle_pct = 28;
      test_random(3, 90);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(3, 90);
      test_backpressure();

      drain_results();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: triangle_plane_clipper_top.f
src/tpc_pkg.sv
src/tpc_div_pipe.sv
src/triangle_plane_clipper_top.sv
src/tpc_checker.sv
sim/tb_triangle_plane_clipper_top.sv
